// ----- sv/pid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants of the pid step block
// Fixed register widths, saturation limits and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pid_pkg;

	// fixed widths of the registers and the running integral
	localparam int GAIN_W    = 32;
	localparam int STEP_W    = 32;
	localparam int INTEG_W   = 48;
	localparam int CFG_IDX_W = 2;

	// magnitude limit of the derivative and of every gained term
	localparam int HOLD_W = 60;
	localparam logic [HOLD_W-1:0] HOLD_LIMIT = '1;

	// shared multiplier: 32 x 32 per cycle, second operand in two chunks
	localparam int MUL_CHUNK = 32;
	localparam int MUL_B_W   = 2 * MUL_CHUNK;
	localparam int MUL_P_W   = GAIN_W + MUL_CHUNK;

	// step interval after reset, about 0.01 s in Q16.16
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655);

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP   = 2'd0,
		REG_KI   = 2'd1,
		REG_KD   = 2'd2,
		REG_STEP = 2'd3
	} cfg_reg_t;

	// operand pair fed to the shared multiplier
	typedef enum logic [1:0] {
		MUL_INT = 2'd0,
		MUL_P   = 2'd1,
		MUL_I   = 2'd2,
		MUL_D   = 2'd3
	} mul_op_t;

	// controller to datapath
	typedef struct packed {
		logic    load_item;
		logic    div_step;
		logic    div_fin;
		mul_op_t mul_op;
		logic    mul_lo;
		logic    mul_hi;
		logic    mul_acc;
		logic    mul_fin;
		logic    integ_upd;
		logic    sum_add;
		logic    out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic zero_step;
	} status_t;

endpackage

// ----- sv/pid_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_if: item channels of the pid step block
// Valid/ready channels for error samples in and controller results out.
// ----------------------------------------------------------------------------

// error sample channel
interface pid_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] error_sample;

	modport source (output valid, output error_sample, input ready);
	modport sink (input valid, input error_sample, output ready);
endinterface

// result channel
interface pid_out_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] drive_value;
	logic                         output_saturated;
	logic                         zero_step_fault;

	modport source (output valid, output drive_value, output output_saturated,
		output zero_step_fault, input ready);
	modport sink (input valid, input drive_value, input output_saturated,
		input zero_step_fault, output ready);
endinterface

// ----- sv/pid_controller_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_step: parallel-form PID step in signed fixed point
// Top level: sequencer plus datapath, item channels and register port.
// ----------------------------------------------------------------------------
// Each error sample yields one result: the derivative (error difference over
// the step interval), the saturating 48-bit integral update, and the sum of
// the three gained terms saturated to DATA_WIDTH bits, all truncated toward
// zero with FRAC_BITS fraction bits. The block works on one item at a time
// and takes the next sample only after the previous result is loaded into
// the output register; the divider is skipped when the step interval is
// zero. The bit-serial divider yields one quotient bit per cycle; the four
// products then share one 32 x 32 multiplier. A finished result waits in
// an output register, so a new sample is taken while the result is still
// unclaimed. Register writes (index 0 Kp, 1 Ki, 2 Kd, 3 step interval)
// belong between items, while the block is idle.
// ----------------------------------------------------------------------------
module pid_controller_step import pid_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	pid_in_if.sink               sample,
	pid_out_if.source            result
);

	localparam int DIV_STEPS = DATA_WIDTH + 1 + FRAC_BITS;

	cmd_t    cmd;
	status_t status;

	// sequencer
	pid_ctrl #(
		.DIV_STEPS (DIV_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and state
	pid_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.error_sample     (sample.error_sample),
		.cmd              (cmd),
		.status           (status),
		.drive_value      (result.drive_value),
		.output_saturated (result.output_saturated),
		.zero_step_fault  (result.zero_step_fault)
	);

endmodule

// ----- sv/pid_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_dp: datapath of the pid step block
// Configuration registers, controller state, a bit-serial restoring divider
// for the derivative and a shared 32 x 32 multiplier with accumulator for
// the four fixed-point products, plus the saturating adders and output item.
// ----------------------------------------------------------------------------
module pid_dp import pid_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [GAIN_W-1:0]            cfg_data,
	input  logic signed [DATA_WIDTH-1:0] error_sample,
	input  cmd_t                         cmd,
	output status_t                      status,
	output logic signed [DATA_WIDTH-1:0] drive_value,
	output logic                         output_saturated,
	output logic                         zero_step_fault
);

	localparam int DIFF_W = DATA_WIDTH + 1;
	localparam int NUM_W  = DIFF_W + FRAC_BITS;
	localparam int CMP_W  = (NUM_W > HOLD_W) ? NUM_W : HOLD_W + 1;
	localparam int ACC_W  = GAIN_W + MUL_B_W;
	localparam int TERM_W = HOLD_W + 1;
	localparam int ISUM_W = TERM_W + 1;
	localparam int SUM_W  = TERM_W + 2;

	localparam logic signed [ISUM_W-1:0] I_MAX =
		{{(ISUM_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
	localparam logic signed [ISUM_W-1:0] I_MIN = ~I_MAX;
	localparam logic signed [SUM_W-1:0] D_MAX =
		{{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] D_MIN = ~D_MAX;

	// configuration and controller state
	logic signed [GAIN_W-1:0]     kp_q, ki_q, kd_q;
	logic [STEP_W-1:0]            step_q;
	logic signed [INTEG_W-1:0]    integ_q;
	logic signed [DATA_WIDTH-1:0] prev_q;

	// per-item working registers
	logic signed [DATA_WIDTH-1:0] err_q;
	logic                         zero_q;
	logic                         dneg_q;
	logic [STEP_W-1:0]            rem_q;
	logic [NUM_W-1:0]             num_q;
	logic [HOLD_W-1:0]            deriv_mag_q;
	logic                         deriv_neg_q;
	logic [MUL_P_W-1:0]           prod_q;
	logic [ACC_W-1:0]             acc_q;
	logic                         mneg_q;
	logic signed [TERM_W-1:0]     term_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic                         clip_q;

	// output item
	logic signed [DATA_WIDTH-1:0] drive_q;
	logic                         sat_q;
	logic                         zflag_q;

	// combinational values
	logic signed [DIFF_W-1:0]     diff;
	logic [DIFF_W-1:0]            diff_mag;
	logic [STEP_W:0]              rem_sh;
	logic                         rem_ge;
	logic                         quot_over;
	logic [DATA_WIDTH-1:0]        err_mag;
	logic [GAIN_W-1:0]            kp_mag, ki_mag, kd_mag;
	logic [INTEG_W-1:0]           integ_mag;
	logic [GAIN_W-1:0]            mul_a;
	logic [MUL_B_W-1:0]           mul_b;
	logic                         mul_neg;
	logic [MUL_CHUNK-1:0]         b_chunk;
	logic [MUL_P_W-1:0]           prod_d;
	logic [ACC_W-1:0]             acc_sh;
	logic                         term_over;
	logic [HOLD_W-1:0]            term_mag;
	logic signed [ISUM_W-1:0]     isum;
	logic signed [SUM_W-1:0]      sum_next;

	assign status.zero_step = (step_q == '0);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			ki_q   <= '0;
			kd_q   <= '0;
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KP:   kp_q   <= signed'(cfg_data);
				REG_KI:   ki_q   <= signed'(cfg_data);
				REG_KD:   kd_q   <= signed'(cfg_data);
				REG_STEP: step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// error difference against the previous sample
	assign diff     = DIFF_W'(error_sample) - DIFF_W'(prev_q);
	assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

	// one restoring division step: shift in a numerator bit, try subtract
	assign rem_sh    = {rem_q, num_q[NUM_W-1]};
	assign rem_ge    = rem_sh >= {1'b0, step_q};
	assign quot_over = CMP_W'(num_q) > CMP_W'(HOLD_LIMIT);

	// operand magnitudes
	assign err_mag   = err_q[DATA_WIDTH-1] ? DATA_WIDTH'(-err_q) : DATA_WIDTH'(err_q);
	assign kp_mag    = kp_q[GAIN_W-1] ? GAIN_W'(-kp_q) : GAIN_W'(kp_q);
	assign ki_mag    = ki_q[GAIN_W-1] ? GAIN_W'(-ki_q) : GAIN_W'(ki_q);
	assign kd_mag    = kd_q[GAIN_W-1] ? GAIN_W'(-kd_q) : GAIN_W'(kd_q);
	assign integ_mag = integ_q[INTEG_W-1] ? INTEG_W'(-integ_q) : INTEG_W'(integ_q);

	// multiplier operand select
	always_comb begin
		case (cmd.mul_op)
			MUL_INT: begin
				mul_a   = step_q;
				mul_b   = MUL_B_W'(err_mag);
				mul_neg = err_q[DATA_WIDTH-1];
			end
			MUL_P: begin
				mul_a   = kp_mag;
				mul_b   = MUL_B_W'(err_mag);
				mul_neg = kp_q[GAIN_W-1] ^ err_q[DATA_WIDTH-1];
			end
			MUL_I: begin
				mul_a   = ki_mag;
				mul_b   = MUL_B_W'(integ_mag);
				mul_neg = ki_q[GAIN_W-1] ^ integ_q[INTEG_W-1];
			end
			MUL_D: begin
				mul_a   = kd_mag;
				mul_b   = MUL_B_W'(deriv_mag_q);
				mul_neg = kd_q[GAIN_W-1] ^ deriv_neg_q;
			end
			default: begin
				mul_a   = '0;
				mul_b   = '0;
				mul_neg = 1'b0;
			end
		endcase
	end

	assign b_chunk = cmd.mul_hi ? mul_b[MUL_B_W-1:MUL_CHUNK] : mul_b[MUL_CHUNK-1:0];
	assign prod_d  = mul_a * b_chunk;

	// drop fraction bits, bound the magnitude
	assign acc_sh    = acc_q >> FRAC_BITS;
	assign term_over = |acc_sh[ACC_W-1:HOLD_W];
	assign term_mag  = term_over ? HOLD_LIMIT : acc_sh[HOLD_W-1:0];

	// integral and output sums
	assign isum     = ISUM_W'(integ_q) + ISUM_W'(term_q);
	assign sum_next = sum_q + SUM_W'(term_q);

	// controller state: integral and previous error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else begin
			if (cmd.integ_upd) begin
				if (isum > I_MAX)
					integ_q <= I_MAX[INTEG_W-1:0];
				else if (isum < I_MIN)
					integ_q <= I_MIN[INTEG_W-1:0];
				else
					integ_q <= isum[INTEG_W-1:0];
			end
			if (cmd.out_load)
				prev_q <= err_q;
		end
	end

	// item capture and divider
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			err_q  <= error_sample;
			zero_q <= status.zero_step;
			dneg_q <= diff[DIFF_W-1];
			rem_q  <= '0;
			num_q  <= {diff_mag, {FRAC_BITS{1'b0}}};
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? STEP_W'(rem_sh - {1'b0, step_q}) : rem_sh[STEP_W-1:0];
			num_q <= {num_q[NUM_W-2:0], rem_ge};
		end
		if (cmd.div_fin) begin
			deriv_mag_q <= zero_q ? '0 : (quot_over ? HOLD_LIMIT : HOLD_W'(num_q));
			deriv_neg_q <= dneg_q & ~zero_q;
		end
	end

	// shared multiplier and accumulator
	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			prod_q <= prod_d;
			mneg_q <= mul_neg;
		end else if (cmd.mul_hi) begin
			prod_q <= prod_d;
			acc_q  <= ACC_W'(prod_q);
		end else if (cmd.mul_acc) begin
			acc_q <= acc_q + {prod_q, {MUL_CHUNK{1'b0}}};
		end
		if (cmd.mul_fin)
			term_q <= mneg_q ? -TERM_W'(term_mag) : TERM_W'(term_mag);
	end

	// output sum and clip flag
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end else begin
			if (cmd.sum_add)
				sum_q <= sum_next;
			if (cmd.div_fin && !zero_q && quot_over)
				clip_q <= 1'b1;
			if (cmd.mul_fin && term_over)
				clip_q <= 1'b1;
			if (cmd.integ_upd && (isum > I_MAX || isum < I_MIN))
				clip_q <= 1'b1;
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (sum_q > D_MAX)
				drive_q <= D_MAX[DATA_WIDTH-1:0];
			else if (sum_q < D_MIN)
				drive_q <= D_MIN[DATA_WIDTH-1:0];
			else
				drive_q <= sum_q[DATA_WIDTH-1:0];
			sat_q   <= clip_q || sum_q > D_MAX || sum_q < D_MIN;
			zflag_q <= zero_q;
		end
	end

	assign drive_value      = drive_q;
	assign output_saturated = sat_q;
	assign zero_step_fault  = zflag_q;

`ifndef SYNTH
	// a zero step interval always yields a zero derivative
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_fin && zero_q |=> deriv_mag_q == '0)
		else $error("derivative not zero for zero step interval");

	// every item starts with a clean sum and clip flag
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> !clip_q && sum_q == '0)
		else $error("item state not cleared at load");

	// previous error follows the item that was just delivered
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> prev_q == $past(err_q))
		else $error("previous error not updated");
`endif

endmodule

// ----- sv/pid_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_ctrl: sequencer of the pid step block
// Steps the datapath through division, four multiply passes and the
// output load, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module pid_ctrl import pid_pkg::*; #(
	parameter int DIV_STEPS = 49
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_DFIN = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	typedef enum logic [4:0] {
		PH_LO  = 5'b00001,
		PH_HI  = 5'b00010,
		PH_ACC = 5'b00100,
		PH_FIN = 5'b01000,
		PH_USE = 5'b10000
	} phase_t;

	state_t            state_q, state_d;
	phase_t            phase_q, phase_d;
	mul_op_t           op_q, op_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		cmd        = '0;
		cmd.mul_op = op_q;
		state_d    = state_q;
		phase_d    = phase_q;
		op_d       = op_q;
		case (state_q)
			ST_IDLE: begin
				phase_d = PH_LO;
				op_d    = MUL_INT;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = status.zero_step ? ST_DFIN : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = ST_DFIN;
			end
			ST_DFIN: begin
				cmd.div_fin = 1'b1;
				state_d     = ST_MUL;
			end
			ST_MUL: begin
				case (phase_q)
					PH_LO: begin
						cmd.mul_lo = 1'b1;
						phase_d    = PH_HI;
					end
					PH_HI: begin
						cmd.mul_hi = 1'b1;
						phase_d    = PH_ACC;
					end
					PH_ACC: begin
						cmd.mul_acc = 1'b1;
						phase_d     = PH_FIN;
					end
					PH_FIN: begin
						cmd.mul_fin = 1'b1;
						phase_d     = PH_USE;
					end
					PH_USE: begin
						phase_d = PH_LO;
						case (op_q)
							MUL_INT: begin
								cmd.integ_upd = 1'b1;
								op_d          = MUL_P;
							end
							MUL_P: begin
								cmd.sum_add = 1'b1;
								op_d        = MUL_I;
							end
							MUL_I: begin
								cmd.sum_add = 1'b1;
								op_d        = MUL_D;
							end
							MUL_D: begin
								cmd.sum_add = 1'b1;
								state_d     = ST_DONE;
							end
							default: state_d = ST_DONE;
						endcase
					end
					default: phase_d = PH_LO;
				endcase
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_LO;
			op_q    <= MUL_INT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			op_q    <= op_d;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
		end
	end

	// output item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

`ifndef SYNTH
	// one item at a time: no acceptance right after an acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// divider counter stays within the quotient width
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= CNT_W'(DIV_STEPS - 1))
		else $error("divider step count overrun");

	// a result appears only out of the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result valid without completion");

	// the derivative pass is the last multiply pass
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL && phase_q == PH_USE && op_q == MUL_D |=> state_q == ST_DONE)
		else $error("multiply sequence did not finish");
`endif

endmodule

// ----- tb/sv/tb_pid_controller_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_step: self-checking bench for the pid step block
// Runs a short list of hand-picked samples (zero gains after reset, zero step,
// clipped extremes, integral windup, derivative spikes), then random phases
// with new gains between them. Senders run in bursts and the receiver stalls.
// Each result is checked against its typed value or a bit-exact controller model.
// ----------------------------------------------------------------------------
module tb_pid_controller_step;
	import pid_pkg::*;

	localparam int DATA_WIDTH    = 32;
	localparam int FRAC_BITS     = 16;
	localparam int PHASE_ITEMS   = 150;
	localparam int RANDOM_PHASES = 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int REPORT_LIMIT  = 40;
	localparam int TIMEOUT_NS    = 15_000_000;

	localparam logic [31:0] Q_MAX    = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN    = 32'h8000_0000;
	localparam logic [31:0] Q_ONE    = 32'h0001_0000;
	localparam logic [31:0] STEP_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] drive;
		logic                         saturated;
		logic                         zero_step;
	} pid_out_t;

	typedef enum logic {ROW_SETUP, ROW_ERROR} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [31:0] kp, ki, kd, step;
		logic [31:0] err;
		bit          typed;
		pid_out_t    want;
	} stim_row_t;

	typedef struct {
		bit       typed;
		pid_out_t want;
	} hand_t;

	typedef enum int {RX_OPEN, RX_CHOPPY, RX_HOLD} rx_mode_t;
	typedef enum int {SHAPE_SCATTER, SHAPE_HOLD, SHAPE_RAMP} shape_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0]    cfg_data;

	pid_in_if  #(.DATA_WIDTH(DATA_WIDTH)) err_ch ();
	pid_out_if #(.DATA_WIDTH(DATA_WIDTH)) drv_ch ();

	pid_controller_step #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (err_ch),
		.result   (drv_ch)
	);

	// controller model state and register copy
	logic signed [DATA_WIDTH-1:0] kp_gain, ki_gain, kd_gain;
	logic [STEP_W-1:0]            step_q16;
	logic signed [INTEG_W-1:0]    integ_acc;
	logic signed [DATA_WIDTH-1:0] last_err;

	pid_out_t drive_expected_q[$];
	hand_t    hand_q[$];

	int fail_count;
	int items_sent;
	int results_seen;
	int sat_seen;
	int zstep_seen;
	int settings_written;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// magnitude of a signed value as an unsigned 64-bit vector
	function automatic logic [63:0] magnitude(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// bound a wide magnitude to the hold limit and restore its sign
	function automatic longint bound_term(logic [127:0] mag, bit neg, inout bit clip);
		logic [127:0] lim;
		longint v;
		lim = 128'(HOLD_LIMIT);
		if (mag > lim) begin
			mag = lim;
			clip = 1'b1;
		end
		v = longint'(mag[63:0]);
		return neg ? -v : v;
	endfunction

	// fixed-point product, truncated toward zero
	function automatic longint fixed_mul(longint a, longint b, inout bit clip);
		logic [127:0] prod;
		prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		prod = prod >> FRAC_BITS;
		return bound_term(prod, (a < 0) != (b < 0), clip);
	endfunction

	// fixed-point quotient, truncated toward zero, divisor nonzero
	function automatic longint fixed_div(longint a, logic [31:0] d, inout bit clip);
		logic [127:0] quo;
		quo = ({64'd0, magnitude(a)} << FRAC_BITS) / {96'd0, d};
		return bound_term(quo, a < 0, clip);
	endfunction

	function automatic longint clamp_signed(longint v, int w, inout bit clip);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clip = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clip = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// one controller step: derivative, integral update, gained sum
	function automatic pid_out_t compute_drive(logic signed [DATA_WIDTH-1:0] err);
		bit       clip;
		bit       zstep;
		longint   deriv, integ, p_term, i_term, d_term, total;
		pid_out_t r;
		clip  = 1'b0;
		zstep = (step_q16 == '0);
		deriv = 0;
		if (!zstep)
			deriv = fixed_div(longint'(err) - longint'(last_err), step_q16, clip);
		integ = clamp_signed(longint'(integ_acc)
			+ fixed_mul(longint'(err), longint'({32'd0, step_q16}), clip), INTEG_W, clip);
		integ_acc = integ[INTEG_W-1:0];
		p_term = fixed_mul(longint'(kp_gain), longint'(err), clip);
		i_term = fixed_mul(longint'(ki_gain), integ, clip);
		d_term = fixed_mul(longint'(kd_gain), deriv, clip);
		total  = clamp_signed(p_term + i_term + d_term, DATA_WIDTH, clip);
		last_err = err;
		r.drive     = total[DATA_WIDTH-1:0];
		r.saturated = clip;
		r.zero_step = zstep;
		return r;
	endfunction

	// random error sample: mostly small, some wide, some extremes
	function automatic logic [31:0] rand_error();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return Q_MAX;
					2: return Q_MIN;
					3: return 32'd1;
					default: return '1;
				endcase
			end
			1, 2, 3, 4: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			5, 6, 7: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return Q_MAX;
			2: return Q_MIN;
			3: return Q_ONE;
			4, 5, 6: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_step();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'd1;
			2: return STEP_MAX;
			3: return STEP_RESET;
			4, 5, 6, 7: return $urandom_range(1, 32'h0010_0000);
			default: return $urandom();
		endcase
	endfunction

	function automatic stim_row_t setup_row(logic [31:0] kp, ki, kd, step);
		stim_row_t r;
		r.kind  = ROW_SETUP;
		r.kp    = kp;
		r.ki    = ki;
		r.kd    = kd;
		r.step  = step;
		r.err   = '0;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic stim_row_t error_row(logic [31:0] err);
		stim_row_t r;
		r       = setup_row('0, '0, '0, '0);
		r.kind  = ROW_ERROR;
		r.err   = err;
		return r;
	endfunction

	function automatic stim_row_t checked_row(logic [31:0] err, logic [31:0] drive,
		bit sat, bit zstep);
		stim_row_t r;
		r       = error_row(err);
		r.typed = 1'b1;
		r.want  = {drive, sat, zstep};
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (fail_count < REPORT_LIMIT)
			$display("[%0t] mismatch on %s at result %0d: got %0h, want %0h",
				$time, what, results_seen, got, want);
		fail_count++;
	endtask

	// write all four registers back to back, then update the model copy
	task automatic program_regs(logic [31:0] kp, ki, kd, step);
		cfg_we    <= 1'b1;
		cfg_index <= REG_KP;
		cfg_data  <= kp;
		@(posedge clk);
		cfg_index <= REG_KI;
		cfg_data  <= ki;
		@(posedge clk);
		cfg_index <= REG_KD;
		cfg_data  <= kd;
		@(posedge clk);
		cfg_index <= REG_STEP;
		cfg_data  <= step;
		@(posedge clk);
		cfg_we   <= 1'b0;
		kp_gain  = kp;
		ki_gain  = ki;
		kd_gain  = kd;
		step_q16 = step;
		settings_written++;
	endtask

	// present one item and hold it until it is taken
	task automatic drive_item(logic [31:0] err, bit typed, pid_out_t want);
		hand_t h;
		h.typed = typed;
		h.want  = want;
		hand_q.push_back(h);
		err_ch.valid        <= 1'b1;
		err_ch.error_sample <= err;
		do begin
			@(posedge clk);
		end while (!err_ch.ready);
		items_sent++;
	endtask

	task automatic end_burst();
		if (err_ch.valid)
			err_ch.valid <= 1'b0;
	endtask

	// hold off until every expected result has come back
	task automatic wait_idle();
		@(posedge clk);
		while (drive_expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver: open stretches, choppy stretches and long holds
	initial begin
		rx_mode_t mode;
		int       run_left;
		drv_ch.ready = 1'b0;
		mode         = RX_OPEN;
		run_left     = 0;
		forever begin
			@(posedge clk);
			if (run_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 2));
				case (mode)
					RX_OPEN: run_left = $urandom_range(50, 300);
					RX_CHOPPY: run_left = $urandom_range(20, 100);
					default: run_left = $urandom_range(1, 30);
				endcase
			end
			run_left--;
			case (mode)
				RX_OPEN: drv_ch.ready <= 1'b1;
				RX_CHOPPY: drv_ch.ready <= 1'($urandom_range(0, 1));
				default: drv_ch.ready <= 1'b0;
			endcase
		end
	end

	// result checking and prediction on accepted items
	always @(posedge clk) begin
		pid_out_t got, want, pred;
		hand_t    h;
		if (arst_n) begin
			if (drv_ch.valid && drv_ch.ready) begin
				got = {drv_ch.drive_value, drv_ch.output_saturated, drv_ch.zero_step_fault};
				results_seen++;
				if (got.saturated)
					sat_seen++;
				if (got.zero_step)
					zstep_seen++;
				if (drive_expected_q.size() == 0) begin
					report_mismatch("result with nothing expected", got.drive, '0);
				end else begin
					want = drive_expected_q.pop_front();
					if (got.drive !== want.drive)
						report_mismatch("drive_value", got.drive, want.drive);
					if (got.saturated !== want.saturated)
						report_mismatch("output_saturated", got.saturated, want.saturated);
					if (got.zero_step !== want.zero_step)
						report_mismatch("zero_step_fault", got.zero_step, want.zero_step);
				end
			end
			if (err_ch.valid && err_ch.ready) begin
				pred = compute_drive(err_ch.error_sample);
				if (hand_q.size() != 0) begin
					h = hand_q.pop_front();
				end else begin
					h.typed = 1'b0;
					h.want  = '0;
				end
				drive_expected_q.push_back(h.typed ? h.want : pred);
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t   rows[$];
		logic [31:0] err, base, slope;
		shape_t      shape;
		int          sent, burst, gap, drain;

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_KP;
		cfg_data            = '0;
		err_ch.valid        = 1'b0;
		err_ch.error_sample = '0;
		kp_gain             = '0;
		ki_gain             = '0;
		kd_gain             = '0;
		step_q16            = STEP_RESET;
		integ_acc           = '0;
		last_err            = '0;
		fail_count          = 0;
		items_sent          = 0;
		results_seen        = 0;
		sat_seen            = 0;
		zstep_seen          = 0;
		settings_written    = 0;

		// after reset the gains are zero, so the drive is zero whatever the error
		rows.push_back(checked_row('0, '0, 1'b0, 1'b0));
		rows.push_back(checked_row(Q_MAX, '0, 1'b0, 1'b0));
		rows.push_back(checked_row(Q_MIN, '0, 1'b0, 1'b0));
		// zero step interval: derivative forced to zero and flagged
		rows.push_back(setup_row('0, '0, '0, '0));
		rows.push_back(checked_row(32'h0000_1234, '0, 1'b0, 1'b1));
		rows.push_back(error_row(32'hFFFF_0000));
		// unit proportional gain passes the error straight through
		rows.push_back(setup_row(Q_ONE, '0, '0, '0));
		rows.push_back(checked_row(32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1));
		rows.push_back(checked_row(32'hEDCB_A988, 32'hEDCB_A988, 1'b0, 1'b1));
		// extreme proportional gains clip the output both ways
		rows.push_back(setup_row(Q_MAX, '0, '0, '0));
		rows.push_back(checked_row(Q_MAX, Q_MAX, 1'b1, 1'b1));
		rows.push_back(checked_row(Q_MIN, Q_MIN, 1'b1, 1'b1));
		rows.push_back(setup_row(Q_MIN, '0, '0, '0));
		rows.push_back(checked_row(Q_MIN, Q_MAX, 1'b1, 1'b1));
		// widest step: integral winds up and clips at 48 bits
		rows.push_back(setup_row('0, Q_MAX, '0, STEP_MAX));
		rows.push_back(checked_row(Q_MAX, Q_MAX, 1'b1, 1'b0));
		rows.push_back(checked_row(Q_MAX, Q_MAX, 1'b1, 1'b0));
		rows.push_back(error_row(Q_MIN));
		rows.push_back(error_row(Q_MIN));
		rows.push_back(error_row(Q_MIN));
		// smallest step: the derivative term hits the hold limit
		rows.push_back(setup_row('0, '0, Q_MAX, 32'd1));
		rows.push_back(checked_row(Q_MAX, Q_MAX, 1'b1, 1'b0));
		rows.push_back(checked_row(Q_MIN, Q_MIN, 1'b1, 1'b0));
		rows.push_back(setup_row('0, '0, Q_MIN, 32'd1));
		rows.push_back(checked_row(Q_MAX, Q_MIN, 1'b1, 1'b0));
		// moderate gains at the reset step
		rows.push_back(setup_row(32'h0001_8000, 32'h0000_8000, 32'h0000_4000, STEP_RESET));
		rows.push_back(error_row(32'h0001_0000));
		rows.push_back(error_row(32'hFFFF_8000));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed list, back to back between register changes
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_SETUP) begin
				end_burst();
				wait_idle();
				program_regs(rows[i].kp, rows[i].ki, rows[i].kd, rows[i].step);
			end else begin
				drive_item(rows[i].err, rows[i].typed, rows[i].want);
			end
		end

		// random phases: extremes first, then mixed settings
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			end_burst();
			wait_idle();
			case (phase)
				0: program_regs(Q_MAX, Q_MAX, Q_MAX, STEP_MAX);
				1: program_regs(Q_MIN, Q_MIN, Q_MIN, 32'd1);
				2: program_regs(rand_gain(), rand_gain(), rand_gain(), '0);
				default: program_regs(rand_gain(), rand_gain(), rand_gain(), rand_step());
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 12);
				shape = shape_t'($urandom_range(0, 2));
				base  = rand_error();
				slope = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
				for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
					case (shape)
						SHAPE_SCATTER: err = rand_error();
						SHAPE_HOLD: err = base + $urandom_range(0, 255) - 32'd128;
						default: err = base + k * slope;
					endcase
					drive_item(err, 1'b0, '0);
					sent++;
				end
				// gap between bursts, or none for a continuous stream
				if (sent < PHASE_ITEMS && $urandom_range(0, 9) >= 4) begin
					gap = $urandom_range(1, 20);
					end_burst();
					repeat (gap) @(posedge clk);
				end
			end
		end

		// drain the remaining results, then watch for strays
		end_burst();
		drain = 0;
		while (drive_expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (100) @(posedge clk);
		if (drive_expected_q.size() != 0)
			report_mismatch("results never delivered", drive_expected_q.size(), '0);

		$display("covered %0d error samples over %0d register settings, %0d results checked",
			items_sent, settings_written, results_seen);
		$display("%0d results flagged saturation, %0d flagged a zero step interval",
			sat_seen, zstep_seen);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// hard stop if the handshakes hang
	initial begin
		#(TIMEOUT_NS);
		$display("timeout: stimulus or results stalled");
		$display("Regression FAIL");
		$finish;
	end

endmodule
